>>> src/gauss_jordan_rref_macros.svh
// Assertion macros for the reduction engine.
`ifndef GAUSS_JORDAN_RREF_MACROS_SVH
`define GAUSS_JORDAN_RREF_MACROS_SVH

`ifndef SYNTHESIS

`define GJR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define GJR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GJR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define GJR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/gjr_pkg.sv
package gjr_pkg;

    localparam int MAX_ROWS = 8;
    localparam int MAX_COLS = 8;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W   = $clog2(MAX_COLS + 1);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;

    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int TOL_W    = 16;
    localparam int SIZE_W   = 4;
    localparam int IDX_W    = 3;
    localparam int RANK_W   = 4;
    localparam int STEP_W   = 8;
    localparam int QUO_W    = DATA_W + FRAC_W;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    typedef enum logic [2:0] {
        WSRC_STORE,
        WSRC_RDA,
        WSRC_RDB,
        WSRC_QUO,
        WSRC_ELIM
    } wsrc_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_TOP,
        ST_COL_RD,
        ST_COL_CHK,
        ST_SCAN,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SWAP_RD,
        ST_SWAP_W1,
        ST_SWAP_W2,
        ST_PIV_RD,
        ST_PIV_LD,
        ST_PIV_CHK,
        ST_DIV_RD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ELIM_ROW,
        ST_ELIM_FRD,
        ST_ELIM_FLD,
        ST_ELIM_RD,
        ST_ELIM_MUL,
        ST_ELIM_Q,
        ST_ELIM_WR,
        ST_END,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic              store_we;
        logic              store_re;
        logic              rd_en;
        logic              w_we;
        logic              piv_ld;
        logic              fac_ld;
        logic              div_go;
        logic              emit;
        logic              last;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic [ADDR_W-1:0] w_addr;
        wsrc_t             w_src;
        logic [IDX_W-1:0]  out_row;
        logic [IDX_W-1:0]  out_col;
        logic [RANK_W-1:0] rank;
        logic [STEP_W-1:0] steps;
    } cmd_t;

    typedef struct packed {
        logic a_near_zero;
        logic needs_div;
        logic div_done;
    } stat_t;

    function automatic logic [ADDR_W-1:0] mk_addr(input logic [RCNT_W-1:0] r,
                                                 input logic [CCNT_W-1:0] c);
        return {r[ROW_W-1:0], c[COL_W-1:0]};
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    function automatic logic is_near_zero(input logic signed [DATA_W-1:0] v,
                                          input logic [TOL_W-1:0] tol);
        return mag32(v) <= {{(DATA_W-TOL_W){1'b0}}, tol};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat48(input logic signed [QUO_W-1:0] v);
        logic signed [QUO_W-1:0] hi;
        logic signed [QUO_W-1:0] lo;
        hi = QUO_W'(64'sh7FFF_FFFF);
        lo = -hi - QUO_W'(1);
        if (v > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
        if (v < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1]) begin
            return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] q_scale(input logic signed [2*DATA_W-1:0] p);
        logic signed [2*DATA_W-1:0] adj;
        logic signed [2*DATA_W-1:0] shr;
        adj = p[2*DATA_W-1] ? p + (2*DATA_W)'((1 << FRAC_W) - 1) : p;
        shr = adj >>> FRAC_W;
        return sat48(shr[QUO_W-1:0]);
    endfunction

    function automatic logic [STEP_W-1:0] step_inc(input logic [STEP_W-1:0] s);
        return (s == {STEP_W{1'b1}}) ? s : s + STEP_W'(1);
    endfunction

endpackage

>>> src/gjr_div.sv
module gjr_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic signed [gjr_pkg::DATA_W-1:0]   dividend,
    input  logic signed [gjr_pkg::DATA_W-1:0]   divisor,
    output logic                                done,
    output logic signed [gjr_pkg::DATA_W-1:0]   quotient
);
    import gjr_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [DATA_W-1:0]          rem_reg, rem_next;
    logic [QUO_W-1:0]           quo_reg, quo_next;
    logic [DATA_W-1:0]          den_reg, den_next;
    logic                       neg_reg, neg_next;
    logic                       zero_reg, zero_next;
    logic signed [DATA_W-1:0]   res_reg, res_next;
    logic [DATA_W:0]            shifted;
    logic [DATA_W+1:0]          diff;
    logic [QUO_W-1:0]           mag_lim;

    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign mag_lim = QUO_W'(64'h8000_0000);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        res_next  = res_reg;
        if (go)
        begin
            run_next  = 1'b1;
            cnt_next  = CNT_W'(QUO_W);
            rem_next  = '0;
            quo_next  = {mag32(dividend), {FRAC_W{1'b0}}};
            den_next  = mag32(divisor);
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            zero_next = (divisor == '0);
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                if (zero_reg)
                begin
                    res_next = '0;
                end
                else if (neg_reg)
                begin
                    res_next = (quo_reg > mag_lim) ? {1'b1, {(DATA_W-1){1'b0}}}
                                                   : DATA_W'(-quo_reg);
                end
                else
                begin
                    res_next = (quo_reg >= mag_lim) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                    : quo_reg[DATA_W-1:0];
                end
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (!diff[DATA_W+1])
                begin
                    rem_next = diff[DATA_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[DATA_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

>>> src/gjr_dp.sv
module gjr_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gjr_pkg::cmd_t                       cmd,
    input  logic [gjr_pkg::TOL_W-1:0]           near_zero,
    input  logic [gjr_pkg::IDX_W-1:0]           entry_row,
    input  logic [gjr_pkg::IDX_W-1:0]           entry_col,
    input  logic signed [gjr_pkg::DATA_W-1:0]   entry_value,
    output gjr_pkg::stat_t                      stat,
    output logic                                valid,
    output logic [gjr_pkg::IDX_W-1:0]           out_row,
    output logic [gjr_pkg::IDX_W-1:0]           out_col,
    output logic signed [gjr_pkg::DATA_W-1:0]   result_value,
    output logic                                last,
    output logic [gjr_pkg::RANK_W-1:0]          rank,
    output logic [gjr_pkg::STEP_W-1:0]          steps_taken
);
    import gjr_pkg::*;

    logic signed [DATA_W-1:0]   store_mem [DEPTH];
    logic signed [DATA_W-1:0]   work_mem  [DEPTH];
    logic signed [DATA_W-1:0]   store_rd_reg;
    logic signed [DATA_W-1:0]   rd_a_reg;
    logic signed [DATA_W-1:0]   rd_b_reg;
    logic signed [DATA_W-1:0]   piv_reg;
    logic signed [DATA_W-1:0]   fac_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [DATA_W-1:0]   qm_reg;
    logic signed [DATA_W-1:0]   w_data;
    logic signed [DATA_W-1:0]   quo;
    logic                       div_done;
    logic signed [DATA_W:0]     piv_off;
    logic [DATA_W:0]            piv_off_mag;

    logic                       valid_reg;
    logic [IDX_W-1:0]           out_row_reg;
    logic [IDX_W-1:0]           out_col_reg;
    logic signed [DATA_W-1:0]   value_reg;
    logic                       last_reg;
    logic [RANK_W-1:0]          rank_reg;
    logic [STEP_W-1:0]          steps_reg;

    gjr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (rd_a_reg),
        .divisor  (piv_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.store_we)
        begin
            store_mem[{entry_row[ROW_W-1:0], entry_col[COL_W-1:0]}] <= entry_value;
        end
        if (cmd.store_re)
        begin
            store_rd_reg <= store_mem[cmd.addr_a];
        end
    end

    always_comb
    begin
        unique case (cmd.w_src)
            WSRC_STORE: w_data = store_rd_reg;
            WSRC_RDA:   w_data = rd_a_reg;
            WSRC_RDB:   w_data = rd_b_reg;
            WSRC_QUO:   w_data = quo;
            WSRC_ELIM:  w_data = sat33({rd_a_reg[DATA_W-1], rd_a_reg}
                                       - {qm_reg[DATA_W-1], qm_reg});
            default:    w_data = rd_a_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.w_we)
        begin
            work_mem[cmd.w_addr] <= w_data;
        end
        if (cmd.rd_en)
        begin
            rd_a_reg <= work_mem[cmd.addr_a];
            rd_b_reg <= work_mem[cmd.addr_b];
        end
        if (cmd.piv_ld)
        begin
            piv_reg <= rd_a_reg;
        end
        if (cmd.fac_ld)
        begin
            fac_reg <= rd_a_reg;
        end
        prod_reg <= fac_reg * rd_b_reg;
        qm_reg   <= q_scale(prod_reg);
    end

    assign piv_off     = {piv_reg[DATA_W-1], piv_reg} - (DATA_W+1)'(1 << FRAC_W);
    assign piv_off_mag = piv_off[DATA_W] ? (DATA_W+1)'(-piv_off) : (DATA_W+1)'(piv_off);

    assign stat.a_near_zero = is_near_zero(rd_a_reg, near_zero);
    assign stat.needs_div   = piv_off_mag > {{(DATA_W+1-TOL_W){1'b0}}, near_zero};
    assign stat.div_done    = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg <= cmd.out_row;
            out_col_reg <= cmd.out_col;
            value_reg   <= rd_a_reg;
            last_reg    <= cmd.last;
            rank_reg    <= cmd.rank;
            steps_reg   <= cmd.steps;
        end
    end

    assign valid        = valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign result_value = value_reg;
    assign last         = last_reg;
    assign rank         = rank_reg;
    assign steps_taken  = steps_reg;

endmodule

>>> src/gjr_ctrl.sv
module gjr_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          kind,
    input  logic [gjr_pkg::SIZE_W-1:0]    rows_used,
    input  logic [gjr_pkg::SIZE_W-1:0]    cols_used,
    input  gjr_pkg::stat_t                stat,
    output gjr_pkg::cmd_t                 cmd,
    output logic                          busy
);
    import gjr_pkg::*;

    state_t             state_reg, state_next;
    logic [RCNT_W-1:0]  rows_reg, rows_next;
    logic [CCNT_W-1:0]  cols_reg, cols_next;
    logic [RCNT_W-1:0]  row_reg, row_next;
    logic [CCNT_W-1:0]  col_reg, col_next;
    logic [RCNT_W-1:0]  s_reg, s_next;
    logic [RCNT_W-1:0]  r_reg, r_next;
    logic [CCNT_W-1:0]  c_reg, c_next;
    logic [RCNT_W-1:0]  piv_reg, piv_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;

    logic [RCNT_W-1:0]  rows_clamp;
    logic [CCNT_W-1:0]  cols_clamp;
    logic               solve_go;
    logic               c_last;
    logic               r_last;
    logic [CCNT_W-1:0]  col_inc;
    logic               more;

    assign rows_clamp = ({1'b0, rows_used} > (SIZE_W+1)'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS)
                                                                     : RCNT_W'(rows_used);
    assign cols_clamp = ({1'b0, cols_used} > (SIZE_W+1)'(MAX_COLS)) ? CCNT_W'(MAX_COLS)
                                                                     : CCNT_W'(cols_used);
    assign solve_go = start && (kind == KIND_SOLVE);
    assign c_last   = (c_reg == cols_reg - CCNT_W'(1));
    assign r_last   = (r_reg == rows_reg - RCNT_W'(1));
    assign col_inc  = col_reg + CCNT_W'(1);
    assign more     = (row_reg < rows_reg) && (col_reg < cols_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (solve_go && rows_clamp != '0 && cols_clamp != '0)
                begin
                    state_next = ST_COPY_RD;
                end
            ST_COPY_RD:  state_next = ST_COPY_WR;
            ST_COPY_WR:  state_next = (c_last && r_last) ? ST_TOP : ST_COPY_RD;
            ST_TOP:      state_next = more ? ST_COL_RD : ST_END;
            ST_COL_RD:   state_next = ST_COL_CHK;
            ST_COL_CHK:  state_next = stat.a_near_zero ? ST_SCAN : ST_PIV_RD;
            ST_SCAN:
                priority if (s_reg < rows_reg)
                begin
                    state_next = ST_SCAN_RD;
                end
                else if (col_inc < cols_reg)
                begin
                    state_next = ST_COL_RD;
                end
                else
                begin
                    state_next = ST_END;
                end
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = stat.a_near_zero ? ST_SCAN : ST_SWAP_RD;
            ST_SWAP_RD:  state_next = ST_SWAP_W1;
            ST_SWAP_W1:  state_next = ST_SWAP_W2;
            ST_SWAP_W2:  state_next = c_last ? ST_PIV_RD : ST_SWAP_RD;
            ST_PIV_RD:   state_next = ST_PIV_LD;
            ST_PIV_LD:   state_next = ST_PIV_CHK;
            ST_PIV_CHK:  state_next = stat.needs_div ? ST_DIV_RD : ST_ELIM_ROW;
            ST_DIV_RD:   state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (stat.div_done)
                begin
                    state_next = c_last ? ST_ELIM_ROW : ST_DIV_RD;
                end
            ST_ELIM_ROW:
                priority if (r_reg >= rows_reg)
                begin
                    state_next = ST_TOP;
                end
                else if (r_reg == row_reg)
                begin
                    state_next = ST_ELIM_ROW;
                end
                else
                begin
                    state_next = ST_ELIM_FRD;
                end
            ST_ELIM_FRD: state_next = ST_ELIM_FLD;
            ST_ELIM_FLD: state_next = stat.a_near_zero ? ST_ELIM_ROW : ST_ELIM_RD;
            ST_ELIM_RD:  state_next = ST_ELIM_MUL;
            ST_ELIM_MUL: state_next = ST_ELIM_Q;
            ST_ELIM_Q:   state_next = ST_ELIM_WR;
            ST_ELIM_WR:  state_next = c_last ? ST_ELIM_ROW : ST_ELIM_RD;
            ST_END:      state_next = ST_EMIT_RD;
            ST_EMIT_RD:  state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: state_next = (c_last && r_last) ? ST_IDLE : ST_EMIT_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        piv_next   = piv_reg;
        steps_next = steps_reg;
        unique case (state_reg)
            ST_IDLE:
                if (solve_go)
                begin
                    rows_next  = rows_clamp;
                    cols_next  = cols_clamp;
                    r_next     = '0;
                    c_next     = '0;
                    piv_next   = '0;
                    steps_next = '0;
                end
            ST_COPY_WR:
                if (c_last)
                begin
                    c_next = '0;
                    if (r_last)
                    begin
                        steps_next = STEP_W'(1);
                        row_next   = '0;
                        col_next   = '0;
                    end
                    else
                    begin
                        r_next = r_reg + RCNT_W'(1);
                    end
                end
                else
                begin
                    c_next = c_reg + CCNT_W'(1);
                end
            ST_TOP:
                if (more)
                begin
                    steps_next = step_inc(steps_reg);
                end
            ST_COL_CHK:
                if (stat.a_near_zero)
                begin
                    s_next = row_reg + RCNT_W'(1);
                end
            ST_SCAN:
                if (s_reg >= rows_reg)
                begin
                    col_next = col_inc;
                    if (col_inc < cols_reg)
                    begin
                        steps_next = step_inc(steps_reg);
                    end
                end
            ST_SCAN_CHK:
                if (stat.a_near_zero)
                begin
                    s_next = s_reg + RCNT_W'(1);
                end
                else
                begin
                    c_next = '0;
                end
            ST_SWAP_W2:
                if (c_last)
                begin
                    steps_next = step_inc(steps_reg);
                end
                else
                begin
                    c_next = c_reg + CCNT_W'(1);
                end
            ST_PIV_CHK:
                if (stat.needs_div)
                begin
                    c_next = '0;
                end
                else
                begin
                    piv_next = piv_reg + RCNT_W'(1);
                    r_next   = '0;
                end
            ST_DIV_WAIT:
                if (stat.div_done)
                begin
                    if (c_last)
                    begin
                        steps_next = step_inc(steps_reg);
                        piv_next   = piv_reg + RCNT_W'(1);
                        r_next     = '0;
                    end
                    else
                    begin
                        c_next = c_reg + CCNT_W'(1);
                    end
                end
            ST_ELIM_ROW:
                priority if (r_reg >= rows_reg)
                begin
                    row_next = row_reg + RCNT_W'(1);
                    col_next = col_inc;
                end
                else if (r_reg == row_reg)
                begin
                    r_next = r_reg + RCNT_W'(1);
                end
            ST_ELIM_FLD:
                if (stat.a_near_zero)
                begin
                    r_next = r_reg + RCNT_W'(1);
                end
                else
                begin
                    c_next = '0;
                end
            ST_ELIM_WR:
                if (c_last)
                begin
                    steps_next = step_inc(steps_reg);
                    r_next     = r_reg + RCNT_W'(1);
                end
                else
                begin
                    c_next = c_reg + CCNT_W'(1);
                end
            ST_END:
            begin
                steps_next = step_inc(steps_reg);
                r_next     = '0;
                c_next     = '0;
            end
            ST_EMIT_OUT:
                if (c_last)
                begin
                    c_next = '0;
                    r_next = r_reg + RCNT_W'(1);
                end
                else
                begin
                    c_next = c_reg + CCNT_W'(1);
                end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.addr_a   = mk_addr(r_reg, c_reg);
        cmd.addr_b   = mk_addr(row_reg, c_reg);
        cmd.w_addr   = mk_addr(r_reg, c_reg);
        cmd.w_src    = WSRC_RDA;
        cmd.out_row  = r_reg[IDX_W-1:0];
        cmd.out_col  = c_reg[IDX_W-1:0];
        cmd.last     = c_last && r_last;
        cmd.rank     = RANK_W'(piv_reg);
        cmd.steps    = steps_reg;
        unique case (state_reg)
            ST_IDLE:     cmd.store_we = start && (kind == KIND_LOAD);
            ST_COPY_RD:  cmd.store_re = 1'b1;
            ST_COPY_WR:
            begin
                cmd.w_we  = 1'b1;
                cmd.w_src = WSRC_STORE;
            end
            ST_COL_RD,
            ST_PIV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.addr_a = mk_addr(row_reg, col_reg);
            end
            ST_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.addr_a = mk_addr(s_reg, col_reg);
            end
            ST_SWAP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.addr_a = mk_addr(row_reg, c_reg);
                cmd.addr_b = mk_addr(s_reg, c_reg);
            end
            ST_SWAP_W1:
            begin
                cmd.w_we   = 1'b1;
                cmd.w_addr = mk_addr(row_reg, c_reg);
                cmd.w_src  = WSRC_RDB;
            end
            ST_SWAP_W2:
            begin
                cmd.w_we   = 1'b1;
                cmd.w_addr = mk_addr(s_reg, c_reg);
                cmd.w_src  = WSRC_RDA;
            end
            ST_PIV_LD:   cmd.piv_ld = 1'b1;
            ST_DIV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.addr_a = mk_addr(row_reg, c_reg);
            end
            ST_DIV_GO:   cmd.div_go = 1'b1;
            ST_DIV_WAIT:
            begin
                cmd.w_we   = stat.div_done;
                cmd.w_addr = mk_addr(row_reg, c_reg);
                cmd.w_src  = WSRC_QUO;
            end
            ST_ELIM_FRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.addr_a = mk_addr(r_reg, col_reg);
            end
            ST_ELIM_FLD: cmd.fac_ld = 1'b1;
            ST_ELIM_RD:  cmd.rd_en = 1'b1;
            ST_ELIM_WR:
            begin
                cmd.w_we  = 1'b1;
                cmd.w_src = WSRC_ELIM;
            end
            ST_EMIT_RD:  cmd.rd_en = 1'b1;
            ST_EMIT_OUT: cmd.emit = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rows_reg  <= '0;
            cols_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            s_reg     <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            piv_reg   <= '0;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            s_reg     <= s_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            piv_reg   <= piv_next;
            steps_reg <= steps_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> src/gauss_jordan_rref.sv
// Channel   Handshake                        Payload
// input     start & !busy                    kind, entry_row, entry_col, entry_value
// result    valid (one cycle, no stall)      out_row, out_col, result_value, last,
//                                            rank, steps_taken
// config    psel & penable & pwrite          paddr, pwdata (prdata on reads)
//
// A load transaction leaves busy low.
// A solve copies the matrix, then works through row swaps, pivot divisions (one
// quotient bit per cycle) and eliminated rows, and emits R*C results; the serial
// divider dominates.
// Reset clears the controller, the valid flag and the config registers but not the matrix storage.
// Results cannot be stalled; busy falls in the cycle that carries the final result.
module gauss_jordan_rref (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic [gjr_pkg::IDX_W-1:0]           entry_row,
    input  logic [gjr_pkg::IDX_W-1:0]           entry_col,
    input  logic signed [gjr_pkg::DATA_W-1:0]   entry_value,
    output logic                                valid,
    output logic [gjr_pkg::IDX_W-1:0]           out_row,
    output logic [gjr_pkg::IDX_W-1:0]           out_col,
    output logic signed [gjr_pkg::DATA_W-1:0]   result_value,
    output logic                                last,
    output logic [gjr_pkg::RANK_W-1:0]          rank,
    output logic [gjr_pkg::STEP_W-1:0]          steps_taken,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import gjr_pkg::*;

    `include "gauss_jordan_rref_macros.svh"

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_TOL  = 2'd2;

    logic [SIZE_W-1:0] rows_used_reg;
    logic [SIZE_W-1:0] cols_used_reg;
    logic [TOL_W-1:0]  near_zero_reg;
    logic              cfg_wr;
    cmd_t              cmd;
    stat_t             stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= SIZE_W'(MAX_ROWS);
            cols_used_reg <= SIZE_W'(MAX_COLS);
            near_zero_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ROWS: rows_used_reg <= pwdata[SIZE_W-1:0];
                REG_COLS: cols_used_reg <= pwdata[SIZE_W-1:0];
                REG_TOL:  near_zero_reg <= pwdata[TOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROWS: prdata = 32'(rows_used_reg);
            REG_COLS: prdata = 32'(cols_used_reg);
            REG_TOL:  prdata = 32'(near_zero_reg);
            default:  prdata = '0;
        endcase
    end

    gjr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start && !busy),
        .kind      (kind),
        .rows_used (rows_used_reg),
        .cols_used (cols_used_reg),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    gjr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .near_zero    (near_zero_reg),
        .entry_row    (entry_row),
        .entry_col    (entry_col),
        .entry_value  (entry_value),
        .stat         (stat),
        .valid        (valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .result_value (result_value),
        .last         (last),
        .rank         (rank),
        .steps_taken  (steps_taken)
    );

    `GJR_ASSERT_IMP(a_valid_after_busy, clk, rst_n, valid, $past(busy), "result outside a solve")
    `GJR_ASSERT_NXT(a_quiet_after_last, clk, rst_n, valid && last, !valid, "result after final entry")
    `GJR_ASSERT_IMP(a_busy_ends_on_last, clk, rst_n, $fell(busy), valid && last, "solve ended early")

endmodule

>>> tb/tb.sv
module tb;
    import gjr_pkg::*;

    localparam logic [3:0] REG_ROWS = 4'd0;
    localparam logic [3:0] REG_COLS = 4'd4;
    localparam logic [3:0] REG_TOL  = 4'd8;
    localparam int CYCLE_LIMIT      = 3000000;
    localparam int ITEM_TARGET      = 370;

    typedef struct {
        logic                     kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic [RANK_W-1:0]        rank;
        logic [STEP_W-1:0]        steps;
    } entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic kind = KIND_LOAD;
    logic [IDX_W-1:0] entry_row = '0;
    logic [IDX_W-1:0] entry_col = '0;
    logic signed [DATA_W-1:0] entry_value = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic busy;
    logic valid;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic signed [DATA_W-1:0] result_value;
    logic last;
    logic [RANK_W-1:0] rank;
    logic [STEP_W-1:0] steps_taken;
    logic [31:0] prdata;
    logic pready;

    gauss_jordan_rref u_top (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    request_t pending[$];
    entry_t reduced_q[$];
    int errors = 0;
    int items_queued = 0;
    int cycles = 0;
    int gap = 0;
    bit no_idle = 0;

    logic signed [DATA_W-1:0] store_copy[MAX_ROWS][MAX_COLS];
    bit loaded[MAX_ROWS][MAX_COLS];
    logic [SIZE_W-1:0] cfg_rows = 4'd8;
    logic [SIZE_W-1:0] cfg_cols = 4'd8;
    logic [TOL_W-1:0] cfg_tol = '0;

    function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic bit within_tol(input logic signed [DATA_W-1:0] v);
        longint m;
        m = longint'(v);
        if (m < 0)
            m = -m;
        return m <= longint'(cfg_tol);
    endfunction

    task automatic reduce_and_expect();
        logic signed [DATA_W-1:0] w[MAX_ROWS][MAX_COLS];
        logic signed [DATA_W-1:0] p;
        logic signed [DATA_W-1:0] f;
        logic signed [DATA_W-1:0] t;
        longint d;
        int nr, nc, row, col, r, c, s, pivots, steps;
        bit found, swapped;
        entry_t e;
        nr = (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
        nc = (cfg_cols > MAX_COLS) ? MAX_COLS : cfg_cols;
        if (nr == 0 || nc == 0)
            return;
        for (r = 0; r < nr; r++)
            for (c = 0; c < nc; c++)
                w[r][c] = store_copy[r][c];
        steps = 1;
        pivots = 0;
        col = 0;
        for (row = 0; row < nr && col < nc; row++)
        begin
            found = 0;
            while (col < nc && !found)
            begin
                steps++;
                if (within_tol(w[row][col]))
                begin
                    swapped = 0;
                    for (s = row + 1; s < nr && !swapped; s++)
                    begin
                        if (!within_tol(w[s][col]))
                        begin
                            for (c = 0; c < nc; c++)
                            begin
                                t = w[row][c];
                                w[row][c] = w[s][c];
                                w[s][c] = t;
                            end
                            steps++;
                            swapped = 1;
                        end
                    end
                    if (!swapped)
                    begin
                        col++;
                        continue;
                    end
                end
                found = 1;
            end
            if (!found)
                break;
            p = w[row][col];
            d = longint'(p) - 65536;
            if (d < 0)
                d = -d;
            if (d > longint'(cfg_tol))
            begin
                for (c = 0; c < nc; c++)
                    w[row][c] = (p == 0) ? '0
                                : clamp32((longint'(w[row][c]) * 65536) / longint'(p));
                steps++;
            end
            pivots++;
            for (r = 0; r < nr; r++)
            begin
                if (r == row)
                    continue;
                f = w[r][col];
                if (!within_tol(f))
                begin
                    for (c = 0; c < nc; c++)
                        w[r][c] = clamp32(longint'(w[r][c]) - longint'(clamp32(
                                  (longint'(f) * longint'(w[row][c])) / 65536)));
                    steps++;
                end
            end
            col++;
        end
        steps++;
        if (steps > 255)
            steps = 255;
        for (r = 0; r < nr; r++)
            for (c = 0; c < nc; c++)
            begin
                e.row = r[IDX_W-1:0];
                e.col = c[IDX_W-1:0];
                e.value = w[r][c];
                e.last = (r == nr - 1 && c == nc - 1);
                e.rank = pivots[RANK_W-1:0];
                e.steps = steps[STEP_W-1:0];
                reduced_q.push_back(e);
            end
    endtask

    function automatic int next_gap();
        if (no_idle || $urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (kind == KIND_SOLVE)
                    reduce_and_expect();
                else
                    store_copy[entry_row][entry_col] = entry_value;
            end
            if (start && busy)
                start <= 1'b1;
            else if (gap > 0)
            begin
                start <= 1'b0;
                gap <= gap - 1;
            end
            else if (pending.size() > 0)
            begin
                kind <= pending[0].kind;
                entry_row <= pending[0].row;
                entry_col <= pending[0].col;
                entry_value <= pending[0].value;
                void'(pending.pop_front());
                start <= 1'b1;
                gap <= next_gap();
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (reduced_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result row %0d col %0d value %h", $time,
                         out_row, out_col, result_value);
            end
            else
            begin
                entry_t e;
                e = reduced_q.pop_front();
                if (out_row !== e.row || out_col !== e.col || result_value !== e.value
                    || last !== e.last || rank !== e.rank || steps_taken !== e.steps)
                begin
                    errors++;
                    $display("%0t: mismatch expected r%0d c%0d %h last %0d rank %0d steps %0d",
                             $time, e.row, e.col, e.value, e.last, e.rank, e.steps);
                    $display("%0t:          actual   r%0d c%0d %h last %0d rank %0d steps %0d",
                             $time, out_row, out_col, result_value, last, rank, steps_taken);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            REG_ROWS: cfg_rows = data[SIZE_W-1:0];
            REG_COLS: cfg_cols = data[SIZE_W-1:0];
            default:  cfg_tol = data[TOL_W-1:0];
        endcase
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || start || reduced_q.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        while (busy)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic configure(input int r, input int c, input int tol);
        wait_idle();
        apb_write(REG_ROWS, r);
        apb_write(REG_COLS, c);
        apb_write(REG_TOL, tol);
    endtask

    task automatic push_load(input int r, input int c, input logic signed [DATA_W-1:0] v);
        request_t q;
        q.kind = KIND_LOAD;
        q.row = r[IDX_W-1:0];
        q.col = c[IDX_W-1:0];
        q.value = v;
        pending.push_back(q);
        loaded[r][c] = 1;
        items_queued++;
    endtask

    task automatic push_solve();
        request_t q;
        q.kind = KIND_SOLVE;
        q.row = IDX_W'($urandom);
        q.col = IDX_W'($urandom);
        q.value = $urandom;
        pending.push_back(q);
        items_queued++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return (int'($urandom_range(0, 8)) - 4) <<< 16;
            2: return $urandom;
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5: return 65536 + int'($urandom_range(0, 2000)) - 1000;
            6: return int'($urandom_range(0, 140000)) - 70000;
            default: return ((int'($urandom_range(0, 16)) - 8) <<< 16)
                            + int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic random_phase(input int r, input int c, input int tol, input int solves);
        int nr, nc, i, j, k;
        bit fresh;
        configure(r, c, tol);
        no_idle = ($urandom_range(0, 3) == 0);
        nr = (r > MAX_ROWS) ? MAX_ROWS : r;
        nc = (c > MAX_COLS) ? MAX_COLS : c;
        for (k = 0; k < solves; k++)
        begin
            for (i = $urandom_range(0, 5); i > 0; i--)
                push_load($urandom_range(0, 7), $urandom_range(0, 7), pick_value());
            fresh = ($urandom_range(0, 2) == 0);
            for (i = 0; i < nr; i++)
                for (j = 0; j < nc; j++)
                    if (!loaded[i][j] || fresh)
                        push_load(i, j, fresh ? (int'($urandom_range(0, 6)) - 3) <<< 16
                                              : pick_value());
            push_solve();
        end
    endtask

    initial
    begin
        int r, c, tol, sel;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        configure(3, 4, 0);
        push_load(0, 0, 0);
        push_load(0, 1, 32'h7FFF_FFFF);
        push_load(0, 2, 32'h8000_0000);
        push_load(0, 3, 65536);
        push_load(1, 0, 65536);
        push_load(1, 1, 2 <<< 16);
        push_load(1, 2, -1);
        push_load(1, 3, 3 <<< 16);
        push_load(2, 0, 2 <<< 16);
        push_load(2, 1, 4 <<< 16);
        push_load(2, 2, 32'h8000_0000);
        push_load(2, 3, 1);
        push_load(7, 7, -1);
        push_solve();
        configure(2, 2, 65535);
        push_load(0, 0, 65536 + 30000);
        push_load(0, 1, 32'h7FFF_FFFF);
        push_load(1, 0, 100);
        push_load(1, 1, -65536);
        push_solve();
        configure(0, 2, 0);
        push_solve();
        configure(2, 0, 0);
        push_solve();

        while (items_queued < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
            begin
                r = $urandom_range(8, 15);
                c = $urandom_range(8, 15);
            end
            else if (sel == 1)
            begin
                r = $urandom_range(0, 1) ? 0 : 1;
                c = $urandom_range(0, 2);
            end
            else
            begin
                r = $urandom_range(1, 4);
                c = $urandom_range(1, 5);
            end
            case ($urandom_range(0, 4))
                0: tol = 0;
                1: tol = 65535;
                2: tol = $urandom_range(0, 65535);
                default: tol = $urandom_range(0, 300);
            endcase
            random_phase(r, c, tol, (sel == 0) ? 1 : $urandom_range(1, 4));
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/gjr_pkg.sv
src/gjr_div.sv
src/gjr_dp.sv
src/gjr_ctrl.sv
src/gauss_jordan_rref.sv
tb/tb.sv
